[rtl/core/fac_pkg.sv]
// shared types and constants for the fully associative cache hit/miss block
package fac_pkg;

    localparam int LINES_DEF     = 32;
    localparam int ADDR_BITS_DEF = 32;
    localparam int ADDR_W        = 32;
    localparam int VICTIM_W      = 5;
    localparam int VICTIM_CODES  = 32;
    localparam int RUN_W         = 20;
    localparam int TOTAL_W       = 32;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_START  = 1'b1;

    localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic                cmd;
        logic [ADDR_W-1:0]   address;
        logic [VICTIM_W-1:0] victim_choice;
    } in_beat_t;

    typedef struct packed {
        logic               hit;
        logic [RUN_W-1:0]   run_hits;
        logic [RUN_W-1:0]   run_misses;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
    } out_beat_t;

    typedef struct packed {
        logic en;
        logic start;
        logic hit;
    } stats_ctl_t;

    typedef struct packed {
        logic [RUN_W-1:0]   run_hits;
        logic [RUN_W-1:0]   run_misses;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
    } stats_val_t;

endpackage

[rtl/core/fully_assoc_cache_random_replace.sv]
// top level: fully associative cache hit/miss tracker with random replacement
//
//   channel   handshake             beat          dir
//   in        in_valid / in_ready   in_data       in   access or start command
//   out       out_valid / out_ready out_data      out  hit flag and counters
//
// the accept cycle registers a compare in every line cell; the resolve stage then
// reduces the matches, writes the fill or victim line and counts
// a new beat is taken only once the previous one has moved to the output register
// out stalls hold the resolve stage, and with it in_ready, until out_ready
// reset invalidates all lines and clears fill count and counters; no clearing pass
module fully_assoc_cache_random_replace #(
    parameter int LINES     = fac_pkg::LINES_DEF,
    parameter int ADDR_BITS = fac_pkg::ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fac_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fac_pkg::out_beat_t out_data
);
    import fac_pkg::*;

    localparam int IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int FILL_W = $clog2(LINES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINES);

    logic                 pend_reg;
    logic                 pend_next;
    logic                 cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [VICTIM_W-1:0]  victim_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_beat_t            out_data_reg;

    logic                 in_fire;
    logic                 resolve;
    logic                 is_start;
    logic                 any_hit;
    logic                 miss_wr;
    logic                 filling;
    logic [IDX_W-1:0]     victim_idx;
    logic [ADDR_BITS-1:0] in_addr;
    logic [ADDR_BITS+ADDR_W-1:0] addr_wide;
    logic [LINES-1:0]     match_vec;
    logic [LINES-1:0]     wr_vec;
    logic [IDX_W-1:0]     vic_map [VICTIM_CODES];
    stats_ctl_t           st_ctl;
    stats_val_t           st_nxt;

    assign addr_wide = {{ADDR_BITS{1'b0}}, in_data.address};
    assign in_addr   = addr_wide[ADDR_BITS-1:0];

    assign in_ready  = !pend_reg;
    assign in_fire   = in_valid && in_ready;
    assign resolve   = pend_reg && (!out_valid_reg || out_ready);
    assign is_start  = (cmd_reg == CMD_START);
    assign any_hit   = |match_vec;
    assign miss_wr   = resolve && !is_start && !any_hit;
    assign filling   = (fill_reg != FILL_FULL);

    for (genvar k = 0; k < VICTIM_CODES; k++)
    begin : g_vic
        assign vic_map[k] = IDX_W'(k % LINES);
    end

    assign victim_idx = vic_map[victim_reg];

    for (genvar i = 0; i < LINES; i++)
    begin : g_line
        assign wr_vec[i] = miss_wr &&
            (filling ? (fill_reg == FILL_W'(i)) : (victim_idx == IDX_W'(i)));

        fac_cell #(
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (resolve && is_start),
            .wr_en    (wr_vec[i]),
            .wr_addr  (addr_reg),
            .cmp_en   (in_fire),
            .cmp_addr (in_addr),
            .match    (match_vec[i])
        );
    end

    assign st_ctl.en    = resolve;
    assign st_ctl.start = is_start;
    assign st_ctl.hit   = any_hit;

    fac_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (st_ctl),
        .nxt   (st_nxt)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire)
            pend_next = 1'b1;
        else if (resolve)
            pend_next = 1'b0;

        fill_next = fill_reg;
        if (resolve && is_start)
            fill_next = '0;
        else if (miss_wr && filling)
            fill_next = fill_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (resolve)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= in_data.cmd;
            addr_reg   <= in_addr;
            victim_reg <= in_data.victim_choice;
        end
        if (resolve)
        begin
            out_data_reg.hit          <= !is_start && any_hit;
            out_data_reg.run_hits     <= st_nxt.run_hits;
            out_data_reg.run_misses   <= st_nxt.run_misses;
            out_data_reg.total_hits   <= st_nxt.total_hits;
            out_data_reg.total_misses <= st_nxt.total_misses;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/fac_cell.sv]
// one cache line: stored address, valid bit and a registered compare
module fac_cell #(
    parameter int ADDR_BITS = fac_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic                 cmp_en,
    input  logic [ADDR_BITS-1:0] cmp_addr,
    output logic                 match
);
    import fac_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 match_reg;
    logic                 match_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            valid_next = 1'b1;
        end
        match_next = match_reg;
        if (cmp_en)
        begin
            match_next = valid_reg && (addr_reg == cmp_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !clear)
        begin
            addr_reg <= wr_addr;
        end
    end

    assign match = match_reg;

endmodule

[rtl/core/fac_stats.sv]
// run and grand hit/miss counters, all saturating
module fac_stats (
    input  logic               clk,
    input  logic               rst_n,
    input  fac_pkg::stats_ctl_t ctl,
    output fac_pkg::stats_val_t nxt
);
    import fac_pkg::*;

    logic [RUN_W-1:0]   run_hit_reg;
    logic [RUN_W-1:0]   run_miss_reg;
    logic [TOTAL_W-1:0] grand_hit_reg;
    logic [TOTAL_W-1:0] grand_miss_reg;
    logic [RUN_W-1:0]   run_hit_next;
    logic [RUN_W-1:0]   run_miss_next;
    logic [TOTAL_W-1:0] grand_hit_next;
    logic [TOTAL_W-1:0] grand_miss_next;

    always_comb
    begin
        run_hit_next    = run_hit_reg;
        run_miss_next   = run_miss_reg;
        grand_hit_next  = grand_hit_reg;
        grand_miss_next = grand_miss_reg;
        if (ctl.start)
        begin
            run_hit_next  = '0;
            run_miss_next = '0;
        end
        else if (ctl.hit)
        begin
            if (run_hit_reg != RUN_MAX)
                run_hit_next = run_hit_reg + 1'b1;
            if (grand_hit_reg != TOTAL_MAX)
                grand_hit_next = grand_hit_reg + 1'b1;
        end
        else
        begin
            if (run_miss_reg != RUN_MAX)
                run_miss_next = run_miss_reg + 1'b1;
            if (grand_miss_reg != TOTAL_MAX)
                grand_miss_next = grand_miss_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hit_reg    <= '0;
            run_miss_reg   <= '0;
            grand_hit_reg  <= '0;
            grand_miss_reg <= '0;
        end
        else if (ctl.en)
        begin
            run_hit_reg    <= run_hit_next;
            run_miss_reg   <= run_miss_next;
            grand_hit_reg  <= grand_hit_next;
            grand_miss_reg <= grand_miss_next;
        end
    end

    assign nxt.run_hits     = run_hit_next;
    assign nxt.run_misses   = run_miss_next;
    assign nxt.total_hits   = grand_hit_next;
    assign nxt.total_misses = grand_miss_next;

endmodule
